// ----- rtl/fmma_pkg.sv -----
// shared types, codes and float rounding helpers for the matrix multiply-accumulate block
package fmma_pkg;

  localparam int MAX_DIM   = 64;
  localparam int IDX_W     = 12;
  localparam int VAL_W     = 32;
  localparam int DIM_W     = 7;
  localparam int CFG_IDX_W = 3;
  localparam int PROD_W    = 14;

  localparam logic [2:0] OP_LOAD_A = 3'd0;
  localparam logic [2:0] OP_LOAD_B = 3'd1;
  localparam logic [2:0] OP_LOAD_C = 3'd2;
  localparam logic [2:0] OP_RUN    = 3'd3;
  localparam logic [2:0] OP_READ_C = 3'd4;

  localparam logic [CFG_IDX_W-1:0] CFG_A_ROWS      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_A_COLS      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_B_ROWS      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_B_COLS      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_TRANSPOSE_A = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_TRANSPOSE_B = 3'd5;

  localparam logic [1:0] ST_READ = 2'd0;
  localparam logic [1:0] ST_DONE = 2'd1;
  localparam logic [1:0] ST_SKIP = 2'd2;

  localparam logic [DIM_W-1:0] DIM_RESET = 7'd64;
  localparam logic [31:0]      QNAN_DEF  = 32'hFFC0_0000;
  localparam logic [31:0]      QUIET_BIT = 32'h0040_0000;

  typedef enum logic [2:0] {
    CMD_LOAD_A,
    CMD_LOAD_B,
    CMD_LOAD_C,
    CMD_RUN,
    CMD_READ,
    CMD_READ_ZERO
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t        kind;
    logic [IDX_W-1:0] index;
    logic [VAL_W-1:0] value;
  } cmd_t;

  typedef struct packed {
    logic [DIM_W-1:0] m;
    logic [DIM_W-1:0] kd;
    logic [DIM_W-1:0] n;
    logic [DIM_W-1:0] a_cols;
    logic [DIM_W-1:0] b_cols;
    logic             ta;
    logic             tb;
    logic             ok;
  } run_cfg_t;

  typedef struct packed {
    logic [1:0] count;
    logic       full;
  } queue_stat_t;

  typedef enum logic [3:0] {
    BK_IDLE,
    BK_RDOUT,
    BK_SKIP,
    BK_DONE,
    BK_C_RD,
    BK_C_LD,
    BK_AB_RD,
    BK_M1,
    BK_M2,
    BK_M3,
    BK_A1,
    BK_A2,
    BK_A3,
    BK_WB
  } back_state_t;

  function automatic logic [5:0] lzc50(input logic [49:0] v);
    logic [5:0] n;
    n = 6'd50;
    for (int i = 0; i < 50; i++) begin
      if (v[i]) n = 6'(49 - i);
    end
    return n;
  endfunction

  // sig has its leading one at bit 47 and biased exponent e
  function automatic logic [31:0] round_pack(input logic s, input logic signed [10:0] e,
                                             input logic [47:0] sig);
    logic [10:0] sh;
    logic [47:0] shifted;
    logic        sticky;
    logic [23:0] m;
    logic        rnd;
    logic        st;
    logic [24:0] mr;
    logic [9:0]  ef;
    logic [32:0] total;
    logic [31:0] res;
    sh      = '0;
    shifted = sig;
    sticky  = 1'b0;
    ef      = '0;
    if (e <= 11'sd0) begin
      sh = 11'(11'sd1 - e);
      if (sh >= 11'd48) begin
        shifted = '0;
        sticky  = |sig;
      end else begin
        shifted = sig >> sh;
        sticky  = |(sig & ~(48'hFFFF_FFFF_FFFF << sh));
      end
    end else begin
      ef = 10'(e - 11'sd1);
    end
    m     = shifted[47:24];
    rnd   = shifted[23];
    st    = (|shifted[22:0]) | sticky;
    mr    = {1'b0, m} + 25'(rnd & (st | m[0]));
    total = {ef, 23'b0} + 33'(mr);
    if (total[32:23] >= 10'd255) res = {s, 8'hFF, 23'b0};
    else res = {s, total[30:0]};
    return res;
  endfunction

endpackage

// ----- rtl/fmma_ram.sv -----
// generic single-write, single-read ram with registered read
module fmma_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// ----- rtl/fmma_front.sv -----
// front end: config registers, request decode and command queue
module fmma_front (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [2:0]                         in_op,
  input  logic [fmma_pkg::IDX_W-1:0]         in_index,
  input  logic [fmma_pkg::VAL_W-1:0]         in_value,
  input  logic                               cfg_wr_en,
  input  logic [fmma_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [fmma_pkg::DIM_W-1:0]         cfg_wdata,
  output logic                               q_valid,
  output fmma_pkg::cmd_t                     q_cmd,
  input  logic                               q_pop,
  output fmma_pkg::run_cfg_t                 run_cfg,
  output fmma_pkg::queue_stat_t              q_stat
);

  localparam int DEPTH = fmma_pkg::MAX_DIM * fmma_pkg::MAX_DIM;

  logic [fmma_pkg::DIM_W-1:0] a_rows_r, a_cols_r, b_rows_r, b_cols_r;
  logic                       ta_r, tb_r;

  fmma_pkg::cmd_t     q_r [2];
  logic               wp_r, rp_r;
  logic [1:0]         cnt_r;
  fmma_pkg::cmd_kind_t kind;
  logic               keep;
  logic               in_rng;
  logic               push;
  logic [fmma_pkg::DIM_W-1:0] kb;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_rows_r <= fmma_pkg::DIM_RESET;
      a_cols_r <= fmma_pkg::DIM_RESET;
      b_rows_r <= fmma_pkg::DIM_RESET;
      b_cols_r <= fmma_pkg::DIM_RESET;
      ta_r     <= 1'b0;
      tb_r     <= 1'b0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        fmma_pkg::CFG_A_ROWS:      a_rows_r <= cfg_wdata;
        fmma_pkg::CFG_A_COLS:      a_cols_r <= cfg_wdata;
        fmma_pkg::CFG_B_ROWS:      b_rows_r <= cfg_wdata;
        fmma_pkg::CFG_B_COLS:      b_cols_r <= cfg_wdata;
        fmma_pkg::CFG_TRANSPOSE_A: ta_r     <= cfg_wdata[0];
        fmma_pkg::CFG_TRANSPOSE_B: tb_r     <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  function automatic logic dim_ok(input logic [fmma_pkg::DIM_W-1:0] d);
    return (d != '0) && (int'(d) <= fmma_pkg::MAX_DIM);
  endfunction

  always_comb begin
    run_cfg.m      = ta_r ? a_cols_r : a_rows_r;
    run_cfg.kd     = ta_r ? a_rows_r : a_cols_r;
    kb             = tb_r ? b_cols_r : b_rows_r;
    run_cfg.n      = tb_r ? b_rows_r : b_cols_r;
    run_cfg.a_cols = a_cols_r;
    run_cfg.b_cols = b_cols_r;
    run_cfg.ta     = ta_r;
    run_cfg.tb     = tb_r;
    run_cfg.ok     = dim_ok(a_rows_r) && dim_ok(a_cols_r) && dim_ok(b_rows_r) &&
                     dim_ok(b_cols_r) && (run_cfg.kd == kb);
  end

  always_comb begin
    in_rng = int'(in_index) < DEPTH;
    kind   = fmma_pkg::CMD_LOAD_A;
    keep   = 1'b0;
    unique case (in_op)
      fmma_pkg::OP_LOAD_A: begin
        kind = fmma_pkg::CMD_LOAD_A;
        keep = in_rng;
      end
      fmma_pkg::OP_LOAD_B: begin
        kind = fmma_pkg::CMD_LOAD_B;
        keep = in_rng;
      end
      fmma_pkg::OP_LOAD_C: begin
        kind = fmma_pkg::CMD_LOAD_C;
        keep = in_rng;
      end
      fmma_pkg::OP_RUN: begin
        kind = fmma_pkg::CMD_RUN;
        keep = 1'b1;
      end
      fmma_pkg::OP_READ_C: begin
        kind = in_rng ? fmma_pkg::CMD_READ : fmma_pkg::CMD_READ_ZERO;
        keep = 1'b1;
      end
      default: keep = 1'b0;
    endcase
  end

  assign in_ready = cnt_r != 2'd2;
  assign push     = in_valid && in_ready && keep;
  assign q_valid  = cnt_r != 2'd0;
  assign q_cmd    = q_r[rp_r];
  assign q_stat.count = cnt_r;
  assign q_stat.full  = !in_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wp_r].kind  <= kind;
      q_r[wp_r].index <= in_index;
      q_r[wp_r].value <= in_value;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= !wp_r;
      if (q_pop) rp_r <= !rp_r;
      cnt_r <= cnt_r + 2'(push) - 2'(q_pop);
    end
  end

endmodule

// ----- rtl/fmma_back.sv -----
// back end: matrix stores, run sequencer, float multiply and add, result register
module fmma_back (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       q_valid,
  input  fmma_pkg::cmd_t             q_cmd,
  output logic                       q_pop,
  input  fmma_pkg::run_cfg_t         run_cfg,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [fmma_pkg::VAL_W-1:0] out_result_value,
  output logic [1:0]                 out_status
);

  localparam int DEPTH = fmma_pkg::MAX_DIM * fmma_pkg::MAX_DIM;
  localparam int AW    = $clog2(DEPTH);

  fmma_pkg::back_state_t state_r, state_nxt;

  logic [fmma_pkg::DIM_W-1:0] i_r, j_r, k_r, i_nxt, j_nxt, k_nxt;
  logic zero_r, zero_nxt;
  logic [31:0] acc_r, prod_r;
  logic out_valid_r;
  logic [31:0] out_val_r;
  logic [1:0]  out_st_r;
  logic out_load;
  logic [31:0] out_val_nxt;
  logic [1:0]  out_st_nxt;
  logic out_free;

  logic a_we, b_we, c_we, a_re, b_re, c_re;
  logic [AW-1:0] a_waddr, b_waddr, c_waddr, a_raddr, b_raddr, c_raddr;
  logic [31:0] c_wdata, a_rd, b_rd, c_rd;

  logic [fmma_pkg::PROD_W-1:0] ai_w, bi_w, ci_w;
  logic [fmma_pkg::PROD_W-1:0] i_e, j_e, k_e, acol_e, bcol_e, n_e;

  fmma_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_a_ram (
    .clk, .wr_en(a_we), .wr_addr(a_waddr), .wr_data(q_cmd.value),
    .rd_en(a_re), .rd_addr(a_raddr), .rd_data(a_rd)
  );
  fmma_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_b_ram (
    .clk, .wr_en(b_we), .wr_addr(b_waddr), .wr_data(q_cmd.value),
    .rd_en(b_re), .rd_addr(b_raddr), .rd_data(b_rd)
  );
  fmma_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_c_ram (
    .clk, .wr_en(c_we), .wr_addr(c_waddr), .wr_data(c_wdata),
    .rd_en(c_re), .rd_addr(c_raddr), .rd_data(c_rd)
  );

  always_comb begin
    i_e    = fmma_pkg::PROD_W'(i_r);
    j_e    = fmma_pkg::PROD_W'(j_r);
    k_e    = fmma_pkg::PROD_W'(k_r);
    acol_e = fmma_pkg::PROD_W'(run_cfg.a_cols);
    bcol_e = fmma_pkg::PROD_W'(run_cfg.b_cols);
    n_e    = fmma_pkg::PROD_W'(run_cfg.n);
    ai_w   = run_cfg.ta ? fmma_pkg::PROD_W'(k_e * acol_e + i_e)
                        : fmma_pkg::PROD_W'(i_e * acol_e + k_e);
    bi_w   = run_cfg.tb ? fmma_pkg::PROD_W'(j_e * bcol_e + k_e)
                        : fmma_pkg::PROD_W'(k_e * bcol_e + j_e);
    ci_w   = fmma_pkg::PROD_W'(i_e * n_e + j_e);
  end

  // multiply, stage one
  logic        m1_spec_r, m1_spec;
  logic [31:0] m1_sv_r, m1_sv;
  logic        m1_sign_r, m1_sign;
  logic signed [10:0] m1_exp_r, m1_exp;
  logic [47:0] m1_prod_r, m1_prod;
  logic [47:0] m2_sig_r;
  logic signed [10:0] m2_exp_r;

  always_comb begin
    logic a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;
    logic [7:0] ea, eb;
    ea      = (a_rd[30:23] == 8'd0) ? 8'd1 : a_rd[30:23];
    eb      = (b_rd[30:23] == 8'd0) ? 8'd1 : b_rd[30:23];
    a_nan   = (a_rd[30:23] == 8'hFF) && (a_rd[22:0] != '0);
    b_nan   = (b_rd[30:23] == 8'hFF) && (b_rd[22:0] != '0);
    a_inf   = (a_rd[30:23] == 8'hFF) && (a_rd[22:0] == '0);
    b_inf   = (b_rd[30:23] == 8'hFF) && (b_rd[22:0] == '0);
    a_zero  = a_rd[30:0] == '0;
    b_zero  = b_rd[30:0] == '0;
    m1_sign = a_rd[31] ^ b_rd[31];
    m1_spec = 1'b1;
    if (a_nan) m1_sv = a_rd | fmma_pkg::QUIET_BIT;
    else if (b_nan) m1_sv = b_rd | fmma_pkg::QUIET_BIT;
    else if ((a_inf && b_zero) || (a_zero && b_inf)) m1_sv = fmma_pkg::QNAN_DEF;
    else if (a_inf || b_inf) m1_sv = {m1_sign, 8'hFF, 23'b0};
    else if (a_zero || b_zero) m1_sv = {m1_sign, 31'b0};
    else begin
      m1_sv   = '0;
      m1_spec = 1'b0;
    end
    m1_exp  = $signed({3'b0, ea}) + $signed({3'b0, eb}) - 11'sd126;
    m1_prod = {a_rd[30:23] != 8'd0, a_rd[22:0]} * {b_rd[30:23] != 8'd0, b_rd[22:0]};
  end

  // add, stage one
  logic        a1_spec_r, a1_spec;
  logic [31:0] a1_sv_r, a1_sv;
  logic        a1_zero_r, a1_zero;
  logic        a1_sign_r, a1_sign;
  logic signed [10:0] a1_exp_r, a1_exp;
  logic [49:0] a1_sum_r, a1_sum;
  logic [47:0] a2_sig_r;
  logic signed [10:0] a2_exp_r;

  always_comb begin
    logic x_nan, y_nan, x_inf, y_inf, x_zero, y_zero, x_big;
    logic [31:0] bg, sm;
    logic [7:0] be, se, d;
    logic [49:0] bw, sw0, sw;
    logic stk;
    x_nan  = (acc_r[30:23] == 8'hFF) && (acc_r[22:0] != '0);
    y_nan  = (prod_r[30:23] == 8'hFF) && (prod_r[22:0] != '0);
    x_inf  = (acc_r[30:23] == 8'hFF) && (acc_r[22:0] == '0);
    y_inf  = (prod_r[30:23] == 8'hFF) && (prod_r[22:0] == '0);
    x_zero = acc_r[30:0] == '0;
    y_zero = prod_r[30:0] == '0;
    a1_spec = 1'b1;
    if (x_nan) a1_sv = acc_r | fmma_pkg::QUIET_BIT;
    else if (y_nan) a1_sv = prod_r | fmma_pkg::QUIET_BIT;
    else if (x_inf && y_inf && (acc_r[31] != prod_r[31])) a1_sv = fmma_pkg::QNAN_DEF;
    else if (x_inf) a1_sv = acc_r;
    else if (y_inf) a1_sv = prod_r;
    else if (x_zero && y_zero) a1_sv = {acc_r[31] & prod_r[31], 31'b0};
    else if (x_zero) a1_sv = prod_r;
    else if (y_zero) a1_sv = acc_r;
    else begin
      a1_sv   = '0;
      a1_spec = 1'b0;
    end
    x_big = acc_r[30:0] >= prod_r[30:0];
    bg    = x_big ? acc_r : prod_r;
    sm    = x_big ? prod_r : acc_r;
    be    = (bg[30:23] == 8'd0) ? 8'd1 : bg[30:23];
    se    = (sm[30:23] == 8'd0) ? 8'd1 : sm[30:23];
    d     = be - se;
    bw    = {1'b0, bg[30:23] != 8'd0, bg[22:0], 25'b0};
    sw0   = {1'b0, sm[30:23] != 8'd0, sm[22:0], 25'b0};
    if (d >= 8'd50) begin
      sw  = '0;
      stk = |sw0;
    end else begin
      sw  = sw0 >> d;
      stk = |(sw0 & ~({50{1'b1}} << d));
    end
    sw[0]   = sw[0] | stk;
    a1_sum  = (bg[31] ^ sm[31]) ? bw - sw : bw + sw;
    a1_zero = a1_sum == '0;
    a1_sign = bg[31];
    a1_exp  = $signed({3'b0, be});
  end

  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt   = state_r;
    i_nxt       = i_r;
    j_nxt       = j_r;
    k_nxt       = k_r;
    zero_nxt    = zero_r;
    q_pop       = 1'b0;
    a_we        = 1'b0;
    b_we        = 1'b0;
    c_we        = 1'b0;
    a_re        = 1'b0;
    b_re        = 1'b0;
    c_re        = 1'b0;
    a_waddr     = AW'(q_cmd.index);
    b_waddr     = AW'(q_cmd.index);
    c_waddr     = AW'(q_cmd.index);
    c_wdata     = q_cmd.value;
    a_raddr     = AW'(ai_w);
    b_raddr     = AW'(bi_w);
    c_raddr     = AW'(ci_w);
    out_load    = 1'b0;
    out_val_nxt = '0;
    out_st_nxt  = fmma_pkg::ST_READ;
    unique case (state_r)
      fmma_pkg::BK_IDLE: begin
        if (q_valid) begin
          q_pop = 1'b1;
          case (q_cmd.kind)
            fmma_pkg::CMD_LOAD_A: a_we = 1'b1;
            fmma_pkg::CMD_LOAD_B: b_we = 1'b1;
            fmma_pkg::CMD_LOAD_C: c_we = 1'b1;
            fmma_pkg::CMD_READ: begin
              c_re      = 1'b1;
              c_raddr   = AW'(q_cmd.index);
              zero_nxt  = 1'b0;
              state_nxt = fmma_pkg::BK_RDOUT;
            end
            fmma_pkg::CMD_READ_ZERO: begin
              zero_nxt  = 1'b1;
              state_nxt = fmma_pkg::BK_RDOUT;
            end
            fmma_pkg::CMD_RUN: begin
              i_nxt     = '0;
              j_nxt     = '0;
              state_nxt = run_cfg.ok ? fmma_pkg::BK_C_RD : fmma_pkg::BK_SKIP;
            end
            default: ;
          endcase
        end
      end
      fmma_pkg::BK_RDOUT: begin
        if (out_free) begin
          out_load    = 1'b1;
          out_val_nxt = zero_r ? 32'd0 : c_rd;
          out_st_nxt  = fmma_pkg::ST_READ;
          state_nxt   = fmma_pkg::BK_IDLE;
        end
      end
      fmma_pkg::BK_SKIP: begin
        if (out_free) begin
          out_load   = 1'b1;
          out_st_nxt = fmma_pkg::ST_SKIP;
          state_nxt  = fmma_pkg::BK_IDLE;
        end
      end
      fmma_pkg::BK_DONE: begin
        if (out_free) begin
          out_load   = 1'b1;
          out_st_nxt = fmma_pkg::ST_DONE;
          state_nxt  = fmma_pkg::BK_IDLE;
        end
      end
      fmma_pkg::BK_C_RD: begin
        c_re      = 1'b1;
        state_nxt = fmma_pkg::BK_C_LD;
      end
      fmma_pkg::BK_C_LD: begin
        k_nxt     = '0;
        state_nxt = fmma_pkg::BK_AB_RD;
      end
      fmma_pkg::BK_AB_RD: begin
        a_re      = 1'b1;
        b_re      = 1'b1;
        state_nxt = fmma_pkg::BK_M1;
      end
      fmma_pkg::BK_M1: state_nxt = fmma_pkg::BK_M2;
      fmma_pkg::BK_M2: state_nxt = fmma_pkg::BK_M3;
      fmma_pkg::BK_M3: state_nxt = fmma_pkg::BK_A1;
      fmma_pkg::BK_A1: state_nxt = fmma_pkg::BK_A2;
      fmma_pkg::BK_A2: state_nxt = fmma_pkg::BK_A3;
      fmma_pkg::BK_A3: begin
        if (k_r == run_cfg.kd - 7'd1) begin
          state_nxt = fmma_pkg::BK_WB;
        end else begin
          k_nxt     = k_r + 7'd1;
          state_nxt = fmma_pkg::BK_AB_RD;
        end
      end
      fmma_pkg::BK_WB: begin
        c_we      = 1'b1;
        c_waddr   = AW'(ci_w);
        c_wdata   = acc_r;
        state_nxt = fmma_pkg::BK_C_RD;
        if (j_r == run_cfg.n - 7'd1) begin
          j_nxt = '0;
          if (i_r == run_cfg.m - 7'd1) state_nxt = fmma_pkg::BK_DONE;
          else i_nxt = i_r + 7'd1;
        end else begin
          j_nxt = j_r + 7'd1;
        end
      end
      default: state_nxt = fmma_pkg::BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= fmma_pkg::BK_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_load) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    logic [5:0]  lz;
    logic [49:0] norm;
    i_r    <= i_nxt;
    j_r    <= j_nxt;
    k_r    <= k_nxt;
    zero_r <= zero_nxt;
    if (out_load) begin
      out_val_r <= out_val_nxt;
      out_st_r  <= out_st_nxt;
    end
    if (state_r == fmma_pkg::BK_C_LD) acc_r <= c_rd;
    if (state_r == fmma_pkg::BK_M1) begin
      m1_spec_r <= m1_spec;
      m1_sv_r   <= m1_sv;
      m1_sign_r <= m1_sign;
      m1_exp_r  <= m1_exp;
      m1_prod_r <= m1_prod;
    end
    if (state_r == fmma_pkg::BK_M2) begin
      lz = fmma_pkg::lzc50({m1_prod_r, 2'b00});
      m2_sig_r <= m1_prod_r << lz;
      m2_exp_r <= m1_exp_r - $signed({5'b0, lz});
    end
    if (state_r == fmma_pkg::BK_M3) begin
      prod_r <= m1_spec_r ? m1_sv_r : fmma_pkg::round_pack(m1_sign_r, m2_exp_r, m2_sig_r);
    end
    if (state_r == fmma_pkg::BK_A1) begin
      a1_spec_r <= a1_spec;
      a1_sv_r   <= a1_sv;
      a1_zero_r <= a1_zero;
      a1_sign_r <= a1_sign;
      a1_exp_r  <= a1_exp;
      a1_sum_r  <= a1_sum;
    end
    if (state_r == fmma_pkg::BK_A2) begin
      lz   = fmma_pkg::lzc50(a1_sum_r);
      norm = a1_sum_r << lz;
      a2_sig_r <= {norm[49:3], |norm[2:0]};
      a2_exp_r <= a1_exp_r + 11'sd1 - $signed({5'b0, lz});
    end
    if (state_r == fmma_pkg::BK_A3) begin
      acc_r <= a1_spec_r ? a1_sv_r :
               a1_zero_r ? 32'd0 : fmma_pkg::round_pack(a1_sign_r, a2_exp_r, a2_sig_r);
    end
  end

  assign out_valid        = out_valid_r;
  assign out_result_value = out_val_r;
  assign out_status       = out_st_r;

endmodule

// ----- rtl/float_matrix_multiply_accumulate.sv -----
// top level of the single-precision matrix multiply-accumulate block
//
//  channel | ports                                         | direction
//  --------+-----------------------------------------------+----------
//  in      | in_valid in_ready in_op in_index in_value      | request in
//  out     | out_valid out_ready out_result_value out_status| result out
//  cfg     | cfg_wr_en cfg_index cfg_wdata                  | write only
//
// loads leave the two-entry queue at one per cycle while the back end is idle
// undefined ops are accepted while the queue has room and never enter the queue
// a read result is registered in the read-out state, once the result register is free
// a run computes one C element at a time through the serial multiply-add chain
// synchronous active-low reset clears control state, stores are undefined until written
// a stalled result register stalls the back end; the queue takes requests until full
module float_matrix_multiply_accumulate (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [2:0]                         in_op,
  input  logic [fmma_pkg::IDX_W-1:0]         in_index,
  input  logic [fmma_pkg::VAL_W-1:0]         in_value,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [fmma_pkg::VAL_W-1:0]         out_result_value,
  output logic [1:0]                         out_status,
  input  logic                               cfg_wr_en,
  input  logic [fmma_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [fmma_pkg::DIM_W-1:0]         cfg_wdata
);

  logic                  q_valid;
  logic                  q_pop;
  fmma_pkg::cmd_t        q_cmd;
  fmma_pkg::run_cfg_t    run_cfg;
  fmma_pkg::queue_stat_t q_stat;

  fmma_front u_front (
    .clk, .rst_n,
    .in_valid, .in_ready, .in_op, .in_index, .in_value,
    .cfg_wr_en, .cfg_index, .cfg_wdata,
    .q_valid, .q_cmd, .q_pop, .run_cfg, .q_stat
  );

  fmma_back u_back (
    .clk, .rst_n,
    .q_valid, .q_cmd, .q_pop, .run_cfg,
    .out_valid, .out_ready, .out_result_value, .out_status
  );

  assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != fmma_pkg::ST_READ) |-> out_result_value == '0)
    else $error("run status carries nonzero data");

  assert property (@(posedge clk) disable iff (!rst_n)
    q_stat.count != 2'd3)
    else $error("command queue overflow");

  assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid)
    else $error("pop from empty queue");

endmodule

// ----- tb/sv/tb.sv -----
// testbench for the single-precision matrix multiply-accumulate block
`timescale 1ns / 1ps

class gemm_tracker;
  typedef struct {
    bit [31:0] value;
    bit [1:0]  status;
  } gemm_result_t;

  bit [31:0]    a_mem[4096];
  bit [31:0]    b_mem[4096];
  bit [31:0]    c_mem[4096];
  int unsigned  dims[4];
  bit           ta;
  bit           tb;
  gemm_result_t awaited[$];
  int           errors;

  function new();
    dims   = '{64, 64, 64, 64};
    ta     = 1'b0;
    tb     = 1'b0;
    errors = 0;
  endfunction

  function void set_reg(bit [2:0] idx, bit [6:0] val);
    case (idx)
      fmma_pkg::CFG_A_ROWS:      dims[0] = val;
      fmma_pkg::CFG_A_COLS:      dims[1] = val;
      fmma_pkg::CFG_B_ROWS:      dims[2] = val;
      fmma_pkg::CFG_B_COLS:      dims[3] = val;
      fmma_pkg::CFG_TRANSPOSE_A: ta = val[0];
      fmma_pkg::CFG_TRANSPOSE_B: tb = val[0];
      default: ;
    endcase
  endfunction

  static function real to_real(bit [31:0] w);
    real mag;
    int  ex;
    if (w[30:23] == 8'hFF) begin
      if (w[22:0] != 0) return $bitstoreal(64'h7FF8_0000_0000_0000);
      return $bitstoreal({w[31], 11'h7FF, 52'b0});
    end
    ex  = (w[30:23] == 0) ? 1 : int'(w[30:23]);
    mag = real'((w[30:23] == 0) ? {1'b0, w[22:0]} : {1'b1, w[22:0]}) * (2.0 ** (ex - 150));
    return w[31] ? -mag : mag;
  endfunction

  // round a double (exact or within 53 bits) to single, nearest even
  static function bit [31:0] to_f32(real x);
    bit [63:0] d;
    bit [63:0] sig;
    bit [63:0] q;
    bit [63:0] rem;
    bit [63:0] half;
    int        es;
    int        sh;
    d = $realtobits(x);
    if (d[62:52] == 11'h7FF) begin
      if (d[51:0] != 0) return 32'h7FC0_0000;
      return {d[63], 8'hFF, 23'b0};
    end
    if (d[62:52] == 0) return {d[63], 31'b0};
    es  = int'(d[62:52]) - 1023 + 127;
    sig = {11'b0, 1'b1, d[51:0]};
    sh  = (es >= 1) ? 29 : 30 - es;
    if (sh > 62) sh = 62;
    q    = sig >> sh;
    rem  = sig & ((64'd1 << sh) - 1);
    half = 64'd1 << (sh - 1);
    if (rem > half || (rem == half && q[0])) q++;
    if (es >= 1) begin
      if (q == (64'd1 << 24)) begin
        q  = q >> 1;
        es = es + 1;
      end
      if (es >= 255) return {d[63], 8'hFF, 23'b0};
      return {d[63], es[7:0], q[22:0]};
    end
    return {d[63], q[30:0]};
  endfunction

  function bit [1:0] multiply();
    int unsigned m, kd, kb, n;
    bit [31:0]   acc;
    bit [31:0]   prod;
    bit [31:0]   av;
    bit [31:0]   bv;
    foreach (dims[i]) if (dims[i] == 0 || dims[i] > 64) return fmma_pkg::ST_SKIP;
    m  = ta ? dims[1] : dims[0];
    kd = ta ? dims[0] : dims[1];
    kb = tb ? dims[3] : dims[2];
    n  = tb ? dims[2] : dims[3];
    if (kd != kb) return fmma_pkg::ST_SKIP;
    for (int i = 0; i < m; i++) begin
      for (int j = 0; j < n; j++) begin
        acc = c_mem[i * n + j];
        for (int k = 0; k < kd; k++) begin
          av   = ta ? a_mem[k * dims[1] + i] : a_mem[i * dims[1] + k];
          bv   = tb ? b_mem[j * dims[3] + k] : b_mem[k * dims[3] + j];
          prod = to_f32(to_real(av) * to_real(bv));
          acc  = to_f32(to_real(acc) + to_real(prod));
        end
        c_mem[i * n + j] = acc;
      end
    end
    return fmma_pkg::ST_DONE;
  endfunction

  function void take_request(bit [2:0] op, bit [11:0] idx, bit [31:0] val);
    gemm_result_t r;
    case (op)
      fmma_pkg::OP_LOAD_A: a_mem[idx] = val;
      fmma_pkg::OP_LOAD_B: b_mem[idx] = val;
      fmma_pkg::OP_LOAD_C: c_mem[idx] = val;
      fmma_pkg::OP_RUN: begin
        r.value  = '0;
        r.status = multiply();
        awaited.push_back(r);
      end
      fmma_pkg::OP_READ_C: begin
        r.value  = c_mem[idx];
        r.status = fmma_pkg::ST_READ;
        awaited.push_back(r);
      end
      default: ;
    endcase
  endfunction

  static function bit is_nan(bit [31:0] w);
    return (w[30:23] == 8'hFF) && (w[22:0] != 0);
  endfunction

  function void check_result(bit [31:0] v, bit [1:0] st);
    gemm_result_t r;
    if (awaited.size() == 0) begin
      $display("%0t unexpected result value %h status %0d", $time, v, st);
      errors++;
      return;
    end
    r = awaited.pop_front();
    if (st != r.status) begin
      $display("%0t status mismatch: expected %0d actual %0d", $time, r.status, st);
      errors++;
    end
    if (is_nan(r.value) ? !is_nan(v) : (v != r.value)) begin
      $display("%0t value mismatch: expected %h actual %h", $time, r.value, v);
      errors++;
    end
  endfunction

  function int pending();
    return awaited.size();
  endfunction
endclass

module tb;
  localparam int CYCLE_LIMIT = 3_000_000;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [2:0]  in_op;
  logic [11:0] in_index;
  logic [31:0] in_value;
  logic        out_valid;
  logic        out_ready;
  logic [31:0] out_result_value;
  logic [1:0]  out_status;
  logic        cfg_wr_en;
  logic [2:0]  cfg_index;
  logic [6:0]  cfg_wdata;

  gemm_tracker tracker;
  int          send_idle;
  int          recv_idle;
  int          cycles;
  bit          c_known[4096];
  int          c_list[$];

  float_matrix_multiply_accumulate dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_op(in_op), .in_index(in_index), .in_value(in_value),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_result_value(out_result_value), .out_status(out_status),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) tracker.check_result(out_result_value, out_status);
  end

  function automatic bit [31:0] rand_float();
    bit s;
    s = $urandom_range(1);
    case ($urandom_range(19))
      0: return {s, 31'b0};
      1: return {s, 8'hFF, 23'b0};
      2: return {s, 8'hFF, 23'($urandom_range(32'h7FFFFF, 1))};
      3: return {s, 8'h00, 23'($urandom)};
      4, 5: return $urandom;
      6: return {s, 8'($urandom_range(20, 1)), 23'($urandom)};
      default: return {s, 8'($urandom_range(137, 117)), 23'($urandom)};
    endcase
  endfunction

  task automatic send_req(input bit [2:0] op, input bit [11:0] idx, input bit [31:0] val);
    while ($urandom_range(99) < send_idle) begin
      @(negedge clk);
      in_valid <= 1'b0;
      @(posedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_op    <= op;
    in_index <= idx;
    in_value <= val;
    do @(posedge clk); while (!in_ready);
    tracker.take_request(op, idx, val);
    if (op == fmma_pkg::OP_LOAD_C && !c_known[idx]) begin
      c_known[idx] = 1'b1;
      c_list.push_back(idx);
    end
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic configure(input int ar, input int ac, input int br, input int bc,
                           input bit ta, input bit tb);
    bit [2:0] idx[6];
    int       val[6];
    idx = '{fmma_pkg::CFG_A_ROWS, fmma_pkg::CFG_A_COLS, fmma_pkg::CFG_B_ROWS,
            fmma_pkg::CFG_B_COLS, fmma_pkg::CFG_TRANSPOSE_A, fmma_pkg::CFG_TRANSPOSE_B};
    val = '{ar, ac, br, bc, ta, tb};
    for (int i = 0; i < 6; i++) begin
      @(negedge clk);
      cfg_wr_en <= 1'b1;
      cfg_index <= idx[i];
      cfg_wdata <= 7'(val[i]);
      @(posedge clk);
      tracker.set_reg(idx[i], 7'(val[i]));
    end
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic directed();
    send_req(fmma_pkg::OP_LOAD_C, 12'd4095, 32'hFFFF_FFFF);
    send_req(fmma_pkg::OP_READ_C, 12'd4095, 32'h0);
    send_req(fmma_pkg::OP_LOAD_C, 12'd0, 32'h0);
    send_req(fmma_pkg::OP_READ_C, 12'd0, 32'hFFFF_FFFF);
    for (int i = 5; i < 8; i++) send_req(3'(i), 12'($urandom), $urandom);
    drain();
    configure(1, 1, 1, 1, 0, 0);
    // overflow to infinity
    send_req(fmma_pkg::OP_LOAD_A, 12'd0, 32'h7F7F_FFFF);
    send_req(fmma_pkg::OP_LOAD_B, 12'd0, 32'h7F7F_FFFF);
    send_req(fmma_pkg::OP_RUN, 12'd0, 32'h0);
    send_req(fmma_pkg::OP_READ_C, 12'd0, 32'h0);
    // infinity times zero
    send_req(fmma_pkg::OP_LOAD_A, 12'd0, 32'h7F80_0000);
    send_req(fmma_pkg::OP_LOAD_B, 12'd0, 32'h0);
    send_req(fmma_pkg::OP_RUN, 12'd0, 32'h0);
    send_req(fmma_pkg::OP_READ_C, 12'd0, 32'h0);
    // tie rounds to even zero, signed zero sum
    send_req(fmma_pkg::OP_LOAD_C, 12'd0, 32'h8000_0000);
    send_req(fmma_pkg::OP_LOAD_A, 12'd0, 32'h0000_0001);
    send_req(fmma_pkg::OP_LOAD_B, 12'd0, 32'h3F00_0000);
    send_req(fmma_pkg::OP_RUN, 12'd0, 32'h0);
    send_req(fmma_pkg::OP_READ_C, 12'd0, 32'h0);
    drain();
    // inner mismatch
    configure(1, 1, 2, 1, 0, 0);
    send_req(fmma_pkg::OP_RUN, 12'd0, 32'h0);
    drain();
  endtask

  task automatic phase(input int p);
    int ar, ac, br, bc, m, n;
    bit ta, tb;
    int r;
    ta = $urandom_range(1);
    tb = $urandom_range(1);
    if (p == 0) begin
      ar = 1; ac = 64; br = 64; bc = 1; ta = 0; tb = 0;
    end else if (p == 1) begin
      ar = 64; ac = 1; br = 1; bc = 64; ta = 1; tb = 1;
    end else if (p % 4 == 2) begin
      ar = $urandom_range(6, 1); ac = $urandom_range(6, 1);
      br = $urandom_range(6, 1); bc = $urandom_range(6, 1);
    end else begin
      m = $urandom_range(6, 1); n = $urandom_range(6, 1); r = $urandom_range(6, 1);
      ar = ta ? r : m; ac = ta ? m : r;
      br = tb ? n : r; bc = tb ? r : n;
      if (p % 4 == 3) begin
        case ($urandom_range(3))
          0: ar = (p % 8 == 3) ? 0 : 127;
          1: ac = (p % 8 == 3) ? 0 : 127;
          2: br = (p % 8 == 3) ? 0 : 127;
          default: bc = (p % 8 == 3) ? 0 : 127;
        endcase
      end
    end
    configure(ar, ac, br, bc, ta, tb);
    if (ar >= 1 && ar <= 64 && ac >= 1 && ac <= 64 && br >= 1 && br <= 64 &&
        bc >= 1 && bc <= 64) begin
      m = ta ? ac : ar;
      n = tb ? br : bc;
      for (int i = 0; i < ar * ac; i++) send_req(fmma_pkg::OP_LOAD_A, 12'(i), rand_float());
      for (int i = 0; i < br * bc; i++) send_req(fmma_pkg::OP_LOAD_B, 12'(i), rand_float());
      for (int i = 0; i < m * n; i++) send_req(fmma_pkg::OP_LOAD_C, 12'(i), rand_float());
    end
    for (int i = 0; i < 70; i++) begin
      if (p == 5 && i == 35) drain();
      r = $urandom_range(99);
      if (r < 12) send_req(fmma_pkg::OP_RUN, 12'($urandom), $urandom);
      else if (r < 40)
        send_req(fmma_pkg::OP_READ_C, 12'(c_list[$urandom_range(c_list.size() - 1)]),
                 $urandom);
      else if (r < 45) send_req(3'($urandom_range(7, 5)), 12'($urandom), $urandom);
      else
        send_req(3'($urandom_range(2)),
                 $urandom_range(1) ? 12'($urandom) : 12'($urandom_range(63)), rand_float());
    end
    drain();
  endtask

  initial begin
    clk       = 1'b0;
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_op     = '0;
    in_index  = '0;
    in_value  = '0;
    out_ready = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    cycles    = 0;
    send_idle = 19;
    recv_idle = 58;
    tracker   = new();
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    directed();
    for (int p = 0; p < 12; p++) begin
      if (p == 4) begin
        send_idle = 58;
        recv_idle = 19;
      end else if (p == 8) begin
        send_idle = 0;
        recv_idle = 0;
      end
      phase(p);
    end
    drain();
    if (tracker.errors == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end
endmodule
